@@ src/tbve_pkg.sv @@
// ----------------------------------------------------------------------------
// tbve_pkg
// Types and constants shared by the beacon value extractor modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tbve_pkg;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 40;
  localparam int unsigned KLEN_W     = 4;

  localparam logic [7:0] PREFIX_BYTE = 8'hFE;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MATCH_KEY  = 2'd0,
    REG_KEY_LENGTH = 2'd1,
    REG_MAX_COPY   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_AWAIT = 2'd0,
    PH_KEY   = 2'd1,
    PH_COPY  = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [KLEN_W-1:0] key_len;
    logic [7:0]        max_copy;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] beacon_length;
    logic       first_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic       result_kind;
    logic [7:0] value_byte;
    logic [7:0] copied_count;
  } res_t;

endpackage

`default_nettype wire

@@ src/tbve_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tbve_cfg_regs
// Configuration registers: match key, clamped key length and copy limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbve_cfg_regs #(
  parameter int unsigned KEY_BYTES = 5
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_we,
  input  wire [tbve_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  wire [tbve_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output logic [8*KEY_BYTES-1:0]               key,
  output tbve_pkg::cfg_t                       cfg
);

  localparam int unsigned KEY_W = 8 * KEY_BYTES;

  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] key_nxt;
  logic [2:0]       klen_r;
  logic [7:0]       max_copy_r;

  generate
    if (KEY_W > tbve_pkg::CFG_DATA_W) begin : g_wide
      assign key_nxt = {{(KEY_W - tbve_pkg::CFG_DATA_W){1'b0}}, cfg_wdata};
    end else if (KEY_W == tbve_pkg::CFG_DATA_W) begin : g_equal
      assign key_nxt = cfg_wdata;
    end else begin : g_narrow
      assign key_nxt = cfg_wdata[KEY_W-1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r      <= '0;
      klen_r     <= 3'd1;
      max_copy_r <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_addr)
        tbve_pkg::REG_MATCH_KEY:  key_r      <= key_nxt;
        tbve_pkg::REG_KEY_LENGTH: klen_r     <= cfg_wdata[2:0];
        tbve_pkg::REG_MAX_COPY:   max_copy_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign key = key_r;
  assign cfg.key_len = ({1'b0, klen_r} > tbve_pkg::KLEN_W'(KEY_BYTES)) ?
                       tbve_pkg::KLEN_W'(KEY_BYTES) : {1'b0, klen_r};
  assign cfg.max_copy = max_copy_r;

endmodule

`default_nettype wire

@@ src/tbve_parser.sv @@
// ----------------------------------------------------------------------------
// tbve_parser
// Record walk state and the single-pass next-state and result logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbve_parser #(
  parameter int unsigned KEY_BYTES = 5
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    step,
  input  tbve_pkg::item_t        item,
  input  wire [8*KEY_BYTES-1:0]  key,
  input  tbve_pkg::cfg_t         cfg,
  output tbve_pkg::res_t         res
);

  logic [7:0]       pos_r, pos_cur, pos_nxt;
  logic [8:0]       nrs_r, nrs_cur, nrs_nxt;
  logic [7:0]       rsize_r, rsize_cur, rsize_nxt;
  tbve_pkg::phase_t phase_r, phase_cur, phase_nxt;
  logic             match_r, match_cur, match_nxt;
  logic [7:0]       remain_r, remain_cur, remain_nxt;
  logic [7:0]       copied_r, copied_cur, copied_nxt;

  logic [7:0] b;
  logic [8:0] sum9;
  logic [7:0] n_raw;
  logic [7:0] n_cap;
  logic [8:0] start9;
  logic [8:0] k9;
  logic [7:0] kb;
  logic       hit;
  logic       m;
  logic       emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      nrs_r    <= '0;
      rsize_r  <= '0;
      phase_r  <= tbve_pkg::PH_AWAIT;
      match_r  <= 1'b1;
      remain_r <= '0;
      copied_r <= '0;
    end else if (step) begin
      pos_r    <= pos_nxt;
      nrs_r    <= nrs_nxt;
      rsize_r  <= rsize_nxt;
      phase_r  <= phase_nxt;
      match_r  <= match_nxt;
      remain_r <= remain_nxt;
      copied_r <= copied_nxt;
    end
  end

  always_comb begin
    b = item.data_byte;
    if (item.first_byte) begin
      pos_cur    = '0;
      nrs_cur    = '0;
      rsize_cur  = '0;
      phase_cur  = tbve_pkg::PH_AWAIT;
      match_cur  = 1'b1;
      remain_cur = '0;
      copied_cur = '0;
    end else begin
      pos_cur    = pos_r;
      nrs_cur    = nrs_r;
      rsize_cur  = rsize_r;
      phase_cur  = phase_r;
      match_cur  = match_r;
      remain_cur = remain_r;
      copied_cur = copied_r;
    end

    pos_nxt    = (pos_cur != 8'd255) ? pos_cur + 8'd1 : pos_cur;
    nrs_nxt    = nrs_cur;
    rsize_nxt  = rsize_cur;
    phase_nxt  = phase_cur;
    match_nxt  = match_cur;
    remain_nxt = remain_cur;
    copied_nxt = copied_cur;
    emit       = 1'b0;

    sum9   = {1'b0, pos_cur} + {1'b0, b};
    n_raw  = b - {4'd0, cfg.key_len} - 8'd1;
    n_cap  = (n_raw > cfg.max_copy) ? cfg.max_copy : n_raw;
    start9 = nrs_cur - {1'b0, rsize_cur};
    k9     = {1'b0, pos_cur} - start9 - 9'd1;
    kb     = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (k9 == 9'(i)) begin
        kb = key[8*i +: 8];
      end
    end
    hit = (k9 < 9'(KEY_BYTES)) && (kb == b);
    m   = match_cur && hit;

    if ((pos_cur < item.beacon_length) && (phase_cur != tbve_pkg::PH_DONE)) begin
      if ((pos_cur == 8'd0) && (b == tbve_pkg::PREFIX_BYTE) &&
          (phase_cur == tbve_pkg::PH_AWAIT) && (nrs_cur == 9'd0)) begin
        nrs_nxt = 9'd1;
      end else begin
        case (phase_cur)
          tbve_pkg::PH_AWAIT: begin
            if ({1'b0, pos_cur} == nrs_cur) begin
              if ((b == 8'd0) || (sum9 >= {1'b0, item.beacon_length})) begin
                phase_nxt = tbve_pkg::PH_DONE;
              end else begin
                nrs_nxt   = sum9;
                rsize_nxt = b;
                if (b > {4'd0, cfg.key_len} && n_cap != 8'd0) begin
                  remain_nxt = n_cap;
                  match_nxt  = 1'b1;
                  phase_nxt  = (cfg.key_len == '0) ? tbve_pkg::PH_COPY :
                               tbve_pkg::PH_KEY;
                end
              end
            end
          end
          tbve_pkg::PH_KEY: begin
            match_nxt = m;
            if ((k9 + 9'd1) >= {5'd0, cfg.key_len}) begin
              phase_nxt = m ? tbve_pkg::PH_COPY : tbve_pkg::PH_AWAIT;
            end
          end
          tbve_pkg::PH_COPY: begin
            emit       = 1'b1;
            copied_nxt = copied_cur + 8'd1;
            remain_nxt = remain_cur - 8'd1;
            if (remain_nxt == 8'd0) begin
              phase_nxt = tbve_pkg::PH_DONE;
            end
          end
          default: ;
        endcase
      end
    end

    res.valid        = item.last_byte || emit;
    res.result_kind  = item.last_byte;
    res.value_byte   = item.last_byte ? 8'd0 : b;
    res.copied_count = copied_nxt;
  end

endmodule

`default_nettype wire

@@ src/tlv_beacon_value_extractor_unit.sv @@
// ----------------------------------------------------------------------------
// tlv_beacon_value_extractor_unit
// Extracts the value bytes of the first keyed record from a beacon payload.
// ----------------------------------------------------------------------------
// The block takes one payload byte per clock cycle while the output is not
// stalled, with no gaps required. A byte lands in an input register, is
// parsed by one pass of compare and counter logic against the record walk
// state, and any result is held in an output register; the two registers
// stall together under output backpressure. Matching value bytes leave with
// tlast low; the last byte of a beacon gives a summary with tlast high, zero
// value and the copied count.
`timescale 1ns / 1ps
`default_nettype none

module tlv_beacon_value_extractor_unit #(
  parameter int unsigned KEY_BYTES = 5
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire [tbve_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire [tbve_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire [15:0]                         in_tdata,   // data_byte, beacon_length
  input  wire                                in_tuser,   // first_byte
  input  wire                                in_tlast,   // last_byte
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [15:0]                        out_tdata,  // value_byte, copied_count
  output logic                               out_tlast   // result_kind
);

  logic [8*KEY_BYTES-1:0] key;
  tbve_pkg::cfg_t         cfg;
  tbve_pkg::item_t        item_r;
  tbve_pkg::res_t         res;
  logic                   s1_valid_r;
  logic                   out_valid_r;
  logic [15:0]            out_data_r;
  logic                   out_last_r;
  logic                   step;

  tbve_cfg_regs #(.KEY_BYTES(KEY_BYTES)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .key       (key),
    .cfg       (cfg)
  );

  tbve_parser #(.KEY_BYTES(KEY_BYTES)) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .key   (key),
    .cfg   (cfg),
    .res   (res)
  );

  assign step      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (step) begin
        out_valid_r <= res.valid;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.data_byte     <= in_tdata[7:0];
      item_r.beacon_length <= in_tdata[15:8];
      item_r.first_byte    <= in_tuser;
      item_r.last_byte     <= in_tlast;
    end
    if (step && res.valid) begin
      out_data_r <= {res.copied_count, res.value_byte};
      out_last_r <= res.result_kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

@@ src/tbve_checker.sv @@
// ----------------------------------------------------------------------------
// tbve_checker
// Port-level assertions for the beacon value extractor, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbve_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [15:0] out_tdata,
  input wire        out_tlast
);

  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while no result is waiting");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result transfer changed");

  a_summary_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[7:0] == 8'd0)
    else $error("summary carries a nonzero value byte");

  a_value_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[15:8] != 8'd0)
    else $error("value byte transfer with zero copied count");

endmodule

bind tlv_beacon_value_extractor_unit tbve_checker u_tbve_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the beacon record search and value extractor.
// ----------------------------------------------------------------------------
// Beacon payloads are streamed in one byte per transfer, with random gaps on
// both sides and one long output stall. Every accepted byte goes through a
// local record walk that predicts the value bytes and the end-of-beacon
// summary. Each output transfer is checked field by field against the
// oldest prediction. The run steps through several key, key length and copy
// limit settings, and each setting is written only while the block is idle.
`timescale 1ns / 1ps

module tb;

  localparam int KEY_BYTES = 5;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic [7:0] count;
  } beacon_result_t;

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  tbve_pkg::cfg_reg_t              cfg_addr = tbve_pkg::REG_MATCH_KEY;
  logic [tbve_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [15:0]                     in_tdata = '0;   // data_byte, beacon_length
  logic                            in_tuser = 1'b0; // first_byte
  logic                            in_tlast = 1'b0; // last_byte
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [15:0]                     out_tdata;       // value_byte, copied_count
  logic                            out_tlast;       // result_kind

  tlv_beacon_value_extractor_unit #(.KEY_BYTES(KEY_BYTES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // Configuration as last written, and the record walk state.
  logic [39:0]       key_cfg;
  logic [2:0]        key_len_cfg;
  logic [7:0]        copy_limit;
  logic [7:0]        walk_pos;
  logic [8:0]        rec_next;
  logic [7:0]        rec_size;
  tbve_pkg::phase_t  walk_phase;
  logic              key_ok;
  logic [7:0]        copy_left;
  logic [7:0]        copy_total;

  tbve_pkg::item_t   payload_bytes[$];
  beacon_result_t    awaited_results[$];
  tbve_pkg::item_t   cur_byte;
  beacon_result_t    want;
  int                src_gap = 0;
  int                sink_gap = 0;
  int                hold_left = 0;
  bit                hold_done = 1'b0;
  bit                calm = 1'b0;
  int                results_seen = 0;
  int                err_count = 0;
  int                quiet_cycles = 0;
  int                phase_items = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void restart_walk();
    walk_pos = '0;
    rec_next = '0;
    rec_size = '0;
    walk_phase = tbve_pkg::PH_AWAIT;
    key_ok = 1'b1;
    copy_left = '0;
    copy_total = '0;
  endfunction

  function automatic void track_beacon_byte(input tbve_pkg::item_t it);
    int p, b, blen, klen, start, k, n;
    bit emit;
    beacon_result_t r;
    b = it.data_byte;
    blen = it.beacon_length;
    klen = (key_len_cfg > KEY_BYTES) ? KEY_BYTES : key_len_cfg;
    emit = 1'b0;
    if (it.first_byte) restart_walk();
    p = walk_pos;
    if (p < blen && walk_phase != tbve_pkg::PH_DONE) begin
      if (p == 0 && it.data_byte == tbve_pkg::PREFIX_BYTE &&
          walk_phase == tbve_pkg::PH_AWAIT && rec_next == 0) begin
        rec_next = 9'd1;
      end else if (walk_phase == tbve_pkg::PH_AWAIT) begin
        if (p == rec_next) begin
          if (b == 0 || p + b >= blen) begin
            walk_phase = tbve_pkg::PH_DONE;
          end else begin
            rec_next = 9'(p + b);
            rec_size = it.data_byte;
            if (b > klen) begin
              n = b - klen - 1;
              if (n > copy_limit) n = copy_limit;
              if (n != 0) begin
                copy_left = 8'(n);
                key_ok = 1'b1;
                walk_phase = (klen == 0) ? tbve_pkg::PH_COPY : tbve_pkg::PH_KEY;
              end
            end
          end
        end
      end else if (walk_phase == tbve_pkg::PH_KEY) begin
        start = int'(rec_next) - int'(rec_size);
        k = p - start - 1;
        if (k < KEY_BYTES) begin
          if (key_cfg[8*k +: 8] != it.data_byte) key_ok = 1'b0;
        end else begin
          key_ok = 1'b0;
        end
        if (k + 1 >= klen) walk_phase = key_ok ? tbve_pkg::PH_COPY : tbve_pkg::PH_AWAIT;
      end else if (walk_phase == tbve_pkg::PH_COPY) begin
        emit = 1'b1;
        copy_total = copy_total + 8'd1;
        copy_left = copy_left - 8'd1;
        if (copy_left == 0) walk_phase = tbve_pkg::PH_DONE;
      end
    end
    if (walk_pos < 8'd255) walk_pos = walk_pos + 8'd1;
    if (it.last_byte) begin
      r.kind = 1'b1;
      r.value = 8'd0;
      r.count = copy_total;
      awaited_results.push_back(r);
    end else if (emit) begin
      r.kind = 1'b0;
      r.value = it.data_byte;
      r.count = copy_total;
      awaited_results.push_back(r);
    end
  endfunction

  // Sender: one byte per transfer, with random gaps while not calm.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_beacon_byte(tbve_pkg::item_t'({in_tdata[7:0], in_tdata[15:8],
                                             in_tuser, in_tlast}));
      end
      if (!in_tvalid || in_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_tvalid <= 1'b0;
        end else if (payload_bytes.size() > 0) begin
          cur_byte = payload_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {cur_byte.beacon_length, cur_byte.data_byte};
          in_tuser <= cur_byte.first_byte;
          in_tlast <= cur_byte.last_byte;
          if (!calm && $urandom_range(0, 6) == 0) src_gap = $urandom_range(1, 9);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each transfer, stalls at random and once for a long time.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $error("unexpected result: result_kind %0d value_byte %0d copied_count %0d",
                 out_tlast, out_tdata[7:0], out_tdata[15:8]);
          err_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_tlast !== want.kind) begin
            $error("result_kind expected %0d actual %0d", want.kind, out_tlast);
            err_count++;
          end
          if (out_tdata[7:0] !== want.value) begin
            $error("value_byte expected %0d actual %0d", want.value, out_tdata[7:0]);
            err_count++;
          end
          if (out_tdata[15:8] !== want.count) begin
            $error("copied_count expected %0d actual %0d", want.count, out_tdata[15:8]);
            err_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && results_seen >= 20) begin
        hold_done = 1'b1;
        hold_left = 300;
        out_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) sink_gap = $urandom_range(1, 9);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic put(input logic [7:0] b, input logic [7:0] blen,
                     input logic first, input logic last);
    tbve_pkg::item_t it;
    it.data_byte = b;
    it.beacon_length = blen;
    it.first_byte = first;
    it.last_byte = last;
    payload_bytes.push_back(it);
    phase_items++;
  endtask

  task automatic add_beacon(input bit tidy);
    logic [7:0] body[$];
    int recs, len, i, blen;
    bit aim, drop_first, drop_last;
    drop_first = 1'b0;
    drop_last = 1'b0;
    if ($urandom_range(0, 1)) body.push_back(tbve_pkg::PREFIX_BYTE);
    recs = $urandom_range(1, 4);
    for (int r = 0; r < recs; r++) begin
      len = ($urandom_range(0, 14) == 0) ? $urandom_range(1, 100)
                                         : $urandom_range(1, key_len_cfg + 6);
      aim = $urandom_range(0, 2) != 0;
      body.push_back(8'(len));
      for (i = 1; i < len; i++) begin
        if (aim && i - 1 < KEY_BYTES && i - 1 < key_len_cfg && $urandom_range(0, 7) != 0)
          body.push_back(key_cfg[8*(i-1) +: 8]);
        else
          body.push_back(8'($urandom));
      end
    end
    if ($urandom_range(0, 3) == 0) body.push_back(8'd0);
    len = $urandom_range(0, 3);
    for (i = 0; i < len; i++) body.push_back(8'($urandom));
    blen = body.size();
    if (!tidy) begin
      case ($urandom_range(0, 3))
        0: begin
          body.delete();
          len = $urandom_range(1, 40);
          for (i = 0; i < len; i++) body.push_back(8'($urandom));
          blen = $urandom_range(1, 255);
        end
        1: drop_first = 1'b1;
        2: blen = $urandom_range(1, 255);
        default: drop_last = 1'b1;
      endcase
    end
    for (i = 0; i < body.size(); i++)
      put(body[i], 8'(blen), i == 0 && !drop_first, i == body.size() - 1 && !drop_last);
  endtask

  task automatic write_reg(input tbve_pkg::cfg_reg_t idx,
                           input logic [tbve_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      tbve_pkg::REG_MATCH_KEY:  key_cfg = val;
      tbve_pkg::REG_KEY_LENGTH: key_len_cfg = val[2:0];
      tbve_pkg::REG_MAX_COPY:   copy_limit = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_walk(input logic [39:0] key, input logic [2:0] klen,
                          input logic [7:0] limit);
    write_reg(tbve_pkg::REG_MATCH_KEY, key);
    write_reg(tbve_pkg::REG_KEY_LENGTH, 40'(klen));
    write_reg(tbve_pkg::REG_MAX_COPY, 40'(limit));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Checked between edges so that the sender's queue and valid agree.
  task automatic drain();
    while (payload_bytes.size() != 0 || in_tvalid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    key_cfg = '0;
    key_len_cfg = 3'd1;
    copy_limit = 8'd255;
    restart_walk();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // The first beacon has no first-byte flag and carries a prefix byte.
    put(8'hFE, 8'd5, 1'b0, 1'b0);
    put(8'h03, 8'd5, 1'b0, 1'b0);
    put(8'h00, 8'd5, 1'b0, 1'b0);
    put(8'hAA, 8'd5, 1'b0, 1'b0);
    put(8'h77, 8'd5, 1'b0, 1'b1);
    // Zero record length ends the walk.
    put(8'h00, 8'd2, 1'b1, 1'b0);
    put(8'hFF, 8'd2, 1'b0, 1'b1);
    // A record too short to copy is skipped, and the next one is copied.
    put(8'h02, 8'd6, 1'b1, 1'b0);
    put(8'h00, 8'd6, 1'b0, 1'b0);
    put(8'h03, 8'd6, 1'b0, 1'b0);
    put(8'h00, 8'd6, 1'b0, 1'b0);
    put(8'hFF, 8'd6, 1'b0, 1'b0);
    put(8'h01, 8'd6, 1'b0, 1'b1);
    // Key mismatch, then a record that runs past the beacon length.
    put(8'h04, 8'd5, 1'b1, 1'b0);
    put(8'h11, 8'd5, 1'b0, 1'b0);
    put(8'h22, 8'd5, 1'b0, 1'b0);
    put(8'h33, 8'd5, 1'b0, 1'b0);
    put(8'h09, 8'd5, 1'b0, 1'b1);
    // A value byte that falls on the last byte.
    put(8'h03, 8'd4, 1'b1, 1'b0);
    put(8'h00, 8'd4, 1'b0, 1'b0);
    put(8'hAB, 8'd4, 1'b0, 1'b1);
    // One-byte beacon, then bytes that carry on without a new first byte.
    put(8'hFE, 8'd1, 1'b1, 1'b1);
    put(8'h02, 8'd255, 1'b0, 1'b0);
    put(8'h00, 8'd255, 1'b0, 1'b1);
    drain();

    for (int ph = 1; ph <= 7; ph++) begin
      case (ph)
        1: set_walk(40'hFF_FFFF_FFFF, 3'd5, 8'd255);
        2: set_walk(40'h0, 3'd0, 8'd1);
        3: set_walk(40'({$urandom, $urandom}), 3'd2, 8'd0);
        4: set_walk(40'({$urandom, $urandom}), 3'd3, 8'd3);
        5: set_walk(40'({$urandom, $urandom}), 3'd5, 8'd255);
        6: set_walk(40'({$urandom, $urandom}), 3'd1, 8'($urandom));
        default: set_walk(40'({$urandom, $urandom}), 3'd4, 8'($urandom_range(1, 20)));
      endcase
      if (ph == 7) calm = 1'b1;
      phase_items = 0;
      while (phase_items < 100) add_beacon($urandom_range(0, 4) != 0);
      drain();
    end

    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/tbve_pkg.sv
src/tbve_cfg_regs.sv
src/tbve_parser.sv
src/tlv_beacon_value_extractor_unit.sv
src/tbve_checker.sv
tb/tb.sv
